// File: src/hmn_pkg.sv
// shared constants for the height-map normal pipeline
`timescale 1ns / 1ps

package hmn_pkg;

  // default widths and fixed-point format
  localparam int HEIGHT_WIDTH_DEF    = 16;
  localparam int SCALE_FRAC_BITS_DEF = 16;
  localparam int SCALE_WIDTH         = 24;

  // result widths
  localparam int NX_WIDTH = 8;
  localparam int NY_WIDTH = 7;
  localparam int NZ_WIDTH = 8;

  // bits of the ratio root floor(254*|v|/L), one root stage per bit
  localparam int ROOT_BITS = 8;

  // 254^2 = 2^16 - 2^10 + 2^2, the snorm range squared
  localparam int SNORM_SQ_SH_HI  = 16;
  localparam int SNORM_SQ_SH_MID = 10;
  localparam int SNORM_SQ_SH_LO  = 2;
  localparam int SNORM_SQ_WIDTH  = 16;

endpackage

// File: src/heightmap_normal_snorm8.sv
// height-map vertex normal from central differences, snorm8 output
`timescale 1ns / 1ps

// Usage:
//   input channel: in_valid / in_stall with the four neighbor heights of one
//   vertex. A word is taken at a clock edge with in_valid high and in_stall low.
//   output channel: out_valid / out_stall with normal_x, normal_y, normal_z,
//   each component rounded half away from zero to 127 * v / |n|.
//   config: cfg_we writes cfg_wdata into normal_scale (unsigned, fixed point
//   with SCALE_FRAC_BITS fraction bits); write only while the pipe is empty.
// The pipe runs through difference, scale multiply, split square, square sum,
// length sum, then one root bit per stage over 8 stages for the
// three components in parallel, then the output register.
// Throughput is one word per cycle; the whole pipe advances together, so the
// rate is set by the out_stall of the receiver alone.
// While a valid result is held with out_stall high, every stage holds and
// in_stall is raised; nothing is lost or repeated. Bubbles do not raise stall.
// Synchronous reset clears all valid bits and sets normal_scale to 1.0.
module heightmap_normal_snorm8 #(
  parameter int HEIGHT_WIDTH    = hmn_pkg::HEIGHT_WIDTH_DEF,
  parameter int SCALE_FRAC_BITS = hmn_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [HEIGHT_WIDTH-1:0]      height_left,
  input  logic signed [HEIGHT_WIDTH-1:0]      height_right,
  input  logic signed [HEIGHT_WIDTH-1:0]      height_down,
  input  logic signed [HEIGHT_WIDTH-1:0]      height_up,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hmn_pkg::NX_WIDTH-1:0] normal_x,
  output logic        [hmn_pkg::NY_WIDTH-1:0] normal_y,
  output logic signed [hmn_pkg::NZ_WIDTH-1:0] normal_z,
  input  logic                                cfg_we,
  input  logic [hmn_pkg::SCALE_WIDTH-1:0]     cfg_wdata
);

  localparam int SW    = hmn_pkg::SCALE_WIDTH;
  localparam int RB    = hmn_pkg::ROOT_BITS;
  localparam int MW    = HEIGHT_WIDTH + 1;
  localparam int AW    = MW + SW;
  localparam int H     = (AW + 1) / 2;
  localparam int GW    = AW - H;
  localparam int HHW   = 2 * GW;
  localparam int HLW   = GW + H;
  localparam int LLW   = 2 * H;
  localparam int SQW   = 2 * AW;
  localparam int LW    = SQW + 2;
  localparam int TW    = SQW + hmn_pkg::SNORM_SQ_WIDTH;
  localparam int NPRE  = 5;
  localparam int TOTAL = NPRE + RB + 1;
  localparam logic [SW-1:0] SCALE_ONE = SW'(1) << SCALE_FRAC_BITS;
  localparam logic [LW-1:0] LEN_B     = LW'(1) << (2 * SCALE_FRAC_BITS);
  localparam logic [TW-1:0] TGT_B     = (TW'(1) << (2 * SCALE_FRAC_BITS + 16))
                                      - (TW'(1) << (2 * SCALE_FRAC_BITS + 10))
                                      + (TW'(1) << (2 * SCALE_FRAC_BITS + 2));

  logic adv;
  logic [SW-1:0] normal_scale;
  logic [TOTAL-1:0] vld;

  // whole pipe moves unless a finished word is held
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[TOTAL-1];

  // scale register
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_scale <= SCALE_ONE;
    end else if (cfg_we) begin
      normal_scale <= cfg_wdata;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL-2:0], in_valid};
    end
  end

  // stage 1: differences, sign and magnitude
  logic signed [MW-1:0] dx_cur, dz_cur;
  logic [MW-1:0] s1_mag_x, s1_mag_z;
  logic s1_neg_x, s1_neg_z;

  assign dx_cur = MW'(height_left) - MW'(height_right);
  assign dz_cur = MW'(height_down) - MW'(height_up);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_x <= dx_cur[MW-1];
      s1_neg_z <= dz_cur[MW-1];
      s1_mag_x <= dx_cur[MW-1] ? $unsigned(-dx_cur) : $unsigned(dx_cur);
      s1_mag_z <= dz_cur[MW-1] ? $unsigned(-dz_cur) : $unsigned(dz_cur);
    end
  end

  // stage 2: scale the differences
  logic [AW-1:0] s2_a, s2_c;
  logic s2_neg_x, s2_neg_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a     <= AW'(s1_mag_x) * AW'(normal_scale);
      s2_c     <= AW'(s1_mag_z) * AW'(normal_scale);
      s2_neg_x <= s1_neg_x;
      s2_neg_z <= s1_neg_z;
    end
  end

  // stage 3: partial products of the squares
  logic [HHW-1:0] s3_hh_a, s3_hh_c;
  logic [HLW-1:0] s3_hl_a, s3_hl_c;
  logic [LLW-1:0] s3_ll_a, s3_ll_c;
  logic s3_neg_x, s3_neg_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_hh_a  <= HHW'(s2_a[AW-1:H]) * HHW'(s2_a[AW-1:H]);
      s3_hl_a  <= HLW'(s2_a[AW-1:H]) * HLW'(s2_a[H-1:0]);
      s3_ll_a  <= LLW'(s2_a[H-1:0]) * LLW'(s2_a[H-1:0]);
      s3_hh_c  <= HHW'(s2_c[AW-1:H]) * HHW'(s2_c[AW-1:H]);
      s3_hl_c  <= HLW'(s2_c[AW-1:H]) * HLW'(s2_c[H-1:0]);
      s3_ll_c  <= LLW'(s2_c[H-1:0]) * LLW'(s2_c[H-1:0]);
      s3_neg_x <= s2_neg_x;
      s3_neg_z <= s2_neg_z;
    end
  end

  // stage 4: assemble the squares
  logic [SQW-1:0] s4_sq_a, s4_sq_c;
  logic s4_neg_x, s4_neg_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sq_a  <= (SQW'(s3_hh_a) << (2 * H)) + (SQW'(s3_hl_a) << (H + 1)) + SQW'(s3_ll_a);
      s4_sq_c  <= (SQW'(s3_hh_c) << (2 * H)) + (SQW'(s3_hl_c) << (H + 1)) + SQW'(s3_ll_c);
      s4_neg_x <= s3_neg_x;
      s4_neg_z <= s3_neg_z;
    end
  end

  // stage 5: squared length and the 254^2 scaled targets
  logic [LW-1:0] s5_len2;
  logic [TW-1:0] s5_tgt_a, s5_tgt_c;
  logic s5_neg_x, s5_neg_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_len2  <= LW'(s4_sq_a) + LW'(s4_sq_c) + LEN_B;
      s5_tgt_a <= (TW'(s4_sq_a) << hmn_pkg::SNORM_SQ_SH_HI)
                - (TW'(s4_sq_a) << hmn_pkg::SNORM_SQ_SH_MID)
                + (TW'(s4_sq_a) << hmn_pkg::SNORM_SQ_SH_LO);
      s5_tgt_c <= (TW'(s4_sq_c) << hmn_pkg::SNORM_SQ_SH_HI)
                - (TW'(s4_sq_c) << hmn_pkg::SNORM_SQ_SH_MID)
                + (TW'(s4_sq_c) << hmn_pkg::SNORM_SQ_SH_LO);
      s5_neg_x <= s4_neg_x;
      s5_neg_z <= s4_neg_z;
    end
  end

  // root stages: floor(254*|v|/L) per component
  logic [RB-1:0] root_x, root_y, root_z;

  hmn_root #(.LEN_WIDTH(LW), .TGT_WIDTH(TW)) u_root_x (
    .clk  (clk),
    .adv  (adv),
    .len2 (s5_len2),
    .tgt  (s5_tgt_a),
    .root (root_x)
  );

  hmn_root #(.LEN_WIDTH(LW), .TGT_WIDTH(TW)) u_root_y (
    .clk  (clk),
    .adv  (adv),
    .len2 (s5_len2),
    .tgt  (TGT_B),
    .root (root_y)
  );

  hmn_root #(.LEN_WIDTH(LW), .TGT_WIDTH(TW)) u_root_z (
    .clk  (clk),
    .adv  (adv),
    .len2 (s5_len2),
    .tgt  (s5_tgt_c),
    .root (root_z)
  );

  // signs ride alongside the root stages
  logic [RB-1:0] rneg_x, rneg_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      rneg_x <= {rneg_x[RB-2:0], s5_neg_x};
      rneg_z <= {rneg_z[RB-2:0], s5_neg_z};
    end
  end

  // rounding: k = floor((x + 1) / 2)
  logic [RB:0] sum_x, sum_y, sum_z;
  logic [RB-1:0] k_x, k_y, k_z;

  assign sum_x = (RB + 1)'(root_x) + (RB + 1)'(1);
  assign sum_y = (RB + 1)'(root_y) + (RB + 1)'(1);
  assign sum_z = (RB + 1)'(root_z) + (RB + 1)'(1);
  assign k_x   = sum_x[RB:1];
  assign k_y   = sum_y[RB:1];
  assign k_z   = sum_z[RB:1];

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      normal_x <= rneg_x[RB-1] ? -$signed(hmn_pkg::NX_WIDTH'(k_x))
                               : $signed(hmn_pkg::NX_WIDTH'(k_x));
      normal_y <= k_y[hmn_pkg::NY_WIDTH-1:0];
      normal_z <= rneg_z[RB-1] ? -$signed(hmn_pkg::NZ_WIDTH'(k_z))
                               : $signed(hmn_pkg::NZ_WIDTH'(k_z));
    end
  end

endmodule

// File: src/hmn_root.sv
// pipelined ratio root: largest x with x^2 * len2 <= tgt, one bit per stage
`timescale 1ns / 1ps

module hmn_root #(
  parameter int LEN_WIDTH = 84,
  parameter int TGT_WIDTH = 98
) (
  input  logic                           clk,
  input  logic                           adv,
  input  logic [LEN_WIDTH-1:0]           len2,
  input  logic [TGT_WIDTH-1:0]           tgt,
  output logic [hmn_pkg::ROOT_BITS-1:0]  root
);

  localparam int RB = hmn_pkg::ROOT_BITS;
  localparam int YW = LEN_WIDTH + RB;
  localparam int DW = LEN_WIDTH + 2 * RB;

  // stage inputs
  logic [TGT_WIDTH-1:0] rem_cur [RB];
  logic [YW-1:0]        acc_cur [RB];
  logic [LEN_WIDTH-1:0] len_cur [RB];
  logic [RB-1:0]        x_cur   [RB];

  // stage registers (the last stage keeps only the root bits)
  logic [TGT_WIDTH-1:0] rem   [RB-1];
  logic [YW-1:0]        acc   [RB-1];
  logic [LEN_WIDTH-1:0] lens  [RB-1];
  logic [RB-1:0]        xbits [RB];

  for (genvar s = 0; s < RB; s++) begin : g_stage
    localparam int BIT = RB - 1 - s;
    logic [DW-1:0] trial;
    logic          take;

    // stage input select
    if (s == 0) begin : g_first
      assign rem_cur[s] = tgt;
      assign acc_cur[s] = '0;
      assign len_cur[s] = len2;
      assign x_cur[s]   = '0;
    end else begin : g_next
      assign rem_cur[s] = rem[s-1];
      assign acc_cur[s] = acc[s-1];
      assign len_cur[s] = lens[s-1];
      assign x_cur[s]   = xbits[s-1];
    end

    // (x + 2^bit)^2 * len2 - x^2 * len2 = 2^(bit+1) * x*len2 + 2^(2*bit) * len2
    assign trial = (DW'(acc_cur[s]) << (BIT + 1)) + (DW'(len_cur[s]) << (2 * BIT));
    assign take  = DW'(rem_cur[s]) >= trial;

    // remainder and running x*len2
    if (s < RB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[s]  <= take ? TGT_WIDTH'(DW'(rem_cur[s]) - trial) : rem_cur[s];
          acc[s]  <= take ? acc_cur[s] + (YW'(len_cur[s]) << BIT) : acc_cur[s];
          lens[s] <= len_cur[s];
        end
      end
    end

    // root bit decision
    always_ff @(posedge clk) begin
      if (adv) begin
        xbits[s] <= x_cur[s] | ({RB{take}} & (RB'(1) << BIT));
      end
    end
  end

  assign root = xbits[RB-1];

endmodule

// File: src/hmn_check.sv
// port-level checks for the height-map normal pipeline, bound to the top level
`timescale 1ns / 1ps

module hmn_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [hmn_pkg::NX_WIDTH-1:0] normal_x,
  input logic        [hmn_pkg::NY_WIDTH-1:0] normal_y,
  input logic signed [hmn_pkg::NZ_WIDTH-1:0] normal_z
);

  // a held word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // a held word does not change
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(normal_x) && $stable(normal_y) && $stable(normal_z))
    else $error("result word changed while stalled");

  // an empty output never back-pressures the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // magnitudes stay within the snorm range
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x != -8'sd128 && normal_z != -8'sd128)
    else $error("normal component out of range");

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result word after reset");

endmodule

bind heightmap_normal_snorm8 hmn_check u_check (.*);
